### rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the frame-fenced ring allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int unsigned BUFFER_BYTES = 16777216;
	localparam int unsigned FRAME_SLOTS  = 3;

	localparam int OFFSET_W = 25;
	localparam int ALIGN_W  = 5;
	localparam int SLOT_W   = 2;
	localparam int STATUS_W = 2;
	localparam int WIDE_W   = 34;
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 32;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FRAME = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IN_PLACE = 2'd0,
		ST_CROSSES  = 2'd1,
		ST_WRAPPED  = 2'd2,
		ST_REFUSED  = 2'd3
	} status_t;

endpackage

### rtl/frame_fenced_ring_allocator.sv
// ----------------------------------------------------------------------------
// frame_fenced_ring_allocator
// Staging ring allocator with a fence taken from the previous frame's start.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the output is not stalled and
// returns exactly one result beat for each, in order. An accepted beat is held
// in an input register; the aligned start, the fit and fence checks and the
// write point update are done in one pass of logic between that register and
// the result register, which also updates the write point, fence and per-frame
// start registers at the same edge. While a result waits on the output, the
// input register takes one more beat and then the input stalls until the
// waiting result leaves.
module frame_fenced_ring_allocator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// request_bytes [24:0], align_log2 [29:25], frame_slot [31:30]
	input  logic [ffra_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
	// op [0]
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// offset [24:0], zero padding [31:25]
	output logic [ffra_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
	// status [1:0]
	output logic [ffra_pkg::STATUS_W-1:0]        m_axis_tuser
);

	localparam int OW = ffra_pkg::OFFSET_W;
	localparam int WW = ffra_pkg::WIDE_W;
	localparam int SW = ffra_pkg::SLOT_W;
	localparam logic [SW:0] SLOTS_L = (SW+1)'(ffra_pkg::FRAME_SLOTS);
	localparam logic [WW-1:0] BUF_L = WW'(ffra_pkg::BUFFER_BYTES);

	logic                          valid_s1;
	ffra_pkg::op_t                 op_s1;
	logic [OW-1:0]                 size_s1;
	logic [ffra_pkg::ALIGN_W-1:0]  align_s1;
	logic [SW-1:0]                 slot_s1;

	logic [OW-1:0] write_point_q;
	logic [OW-1:0] fence_q;
	logic [OW-1:0] frame_start_q [ffra_pkg::FRAME_SLOTS];

	logic                    out_valid_q;
	logic [OW-1:0]           out_offset_q;
	ffra_pkg::status_t       out_status_q;

	logic advance;

	logic [WW-1:0]     amask;
	logic [WW-1:0]     start_w;
	logic [WW-1:0]     end_w;
	logic [WW-1:0]     fence_w;
	logic              fits;
	logic              slot_ok;
	logic [SW-1:0]     prev_slot;
	logic [OW-1:0]     nxt_offset;
	ffra_pkg::status_t nxt_status;
	logic [OW-1:0]     nxt_wp;
	logic [OW-1:0]     nxt_fence;
	logic              wr_table;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		amask     = (WW'(1) << align_s1) - WW'(1);
		start_w   = (WW'(write_point_q) + amask) & ~amask;
		end_w     = start_w + WW'(size_s1);
		fence_w   = WW'(fence_q);
		fits      = end_w <= BUF_L;
		slot_ok   = {1'b0, slot_s1} < SLOTS_L;
		prev_slot = (slot_s1 == '0) ? SW'(ffra_pkg::FRAME_SLOTS - 1) : slot_s1 - SW'(1);
		nxt_offset = '0;
		nxt_status = ffra_pkg::ST_REFUSED;
		nxt_wp     = write_point_q;
		nxt_fence  = fence_q;
		wr_table   = 1'b0;
		if (op_s1 == ffra_pkg::OP_ALLOC) begin
			if (fits) begin
				nxt_offset = start_w[OW-1:0];
				nxt_wp     = end_w[OW-1:0];
				nxt_status = ((start_w < fence_w) && (end_w >= fence_w)) ?
					ffra_pkg::ST_CROSSES : ffra_pkg::ST_IN_PLACE;
			end else if (size_s1 < fence_q) begin
				nxt_wp     = size_s1;
				nxt_status = ffra_pkg::ST_WRAPPED;
			end
		end else begin
			if (slot_ok) begin
				wr_table   = 1'b1;
				nxt_fence  = frame_start_q[prev_slot];
				nxt_offset = frame_start_q[prev_slot];
				nxt_status = ffra_pkg::ST_IN_PLACE;
			end else begin
				nxt_offset = fence_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= ffra_pkg::op_t'(s_axis_tuser);
			size_s1  <= s_axis_tdata[OW-1:0];
			align_s1 <= s_axis_tdata[OW +: ffra_pkg::ALIGN_W];
			slot_s1  <= s_axis_tdata[OW + ffra_pkg::ALIGN_W +: SW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_point_q <= '0;
			fence_q       <= '0;
			for (int i = 0; i < ffra_pkg::FRAME_SLOTS; i++) begin
				frame_start_q[i] <= '0;
			end
		end else if (advance) begin
			write_point_q <= nxt_wp;
			fence_q       <= nxt_fence;
			if (wr_table) begin
				frame_start_q[slot_s1] <= write_point_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_offset_q <= nxt_offset;
			out_status_q <= nxt_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ffra_pkg::TDATA_OUT_W'(out_offset_q);
	assign m_axis_tuser  = out_status_q;

endmodule

### rtl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the frame-fenced ring allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ffra_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
	input logic [ffra_pkg::STATUS_W-1:0]     m_axis_tuser
);

	localparam logic [ffra_pkg::OFFSET_W-1:0] BUF_L =
		ffra_pkg::OFFSET_W'(ffra_pkg::BUFFER_BYTES);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("Stalled output beat changed.");

	a_wrap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ffra_pkg::ST_WRAPPED) |->
		m_axis_tdata == '0)
		else $error("Wrapped grant with a nonzero offset.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[ffra_pkg::TDATA_OUT_W-1:ffra_pkg::OFFSET_W] == '0)
		else $error("Padding bits of the output beat are set.");

	a_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[ffra_pkg::OFFSET_W-1:0] <= BUF_L)
		else $error("Offset lies past the buffer end.");

endmodule

bind frame_fenced_ring_allocator ffra_checker u_ffra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame-fenced ring allocator. Beats go in on the
// slave stream and come out on the master stream. A scoreboard keeps its own
// write point, fence and frame start table, predicts the offset and status of
// each accepted beat, and compares every result beat with the oldest
// prediction. The bench runs a directed part and then random beats, with
// random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffra_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 500;

	typedef struct {
		logic [OFFSET_W-1:0] offset;
		status_t             status;
	} grant_t;

	class grant_scoreboard;
		longint unsigned write_point;
		longint unsigned fence;
		longint unsigned frame_starts[FRAME_SLOTS];
		grant_t          awaited_grants[$];
		int unsigned     mismatches;
		int unsigned     status_count[4];
		int unsigned     frame_marks;

		function new();
			write_point = 0;
			fence = 0;
			foreach (frame_starts[i])
				frame_starts[i] = 0;
			mismatches = 0;
			frame_marks = 0;
			foreach (status_count[i])
				status_count[i] = 0;
		endfunction

		function int pending();
			return awaited_grants.size();
		endfunction

		function void note_request(op_t op, logic [OFFSET_W-1:0] bytes,
				logic [ALIGN_W-1:0] align, logic [SLOT_W-1:0] slot);
			longint unsigned amask;
			longint unsigned start;
			longint unsigned stop;
			int unsigned     prev;
			grant_t          g;
			g.offset = '0;
			g.status = ST_REFUSED;
			if (op == OP_ALLOC) begin
				amask = (64'd1 << align) - 64'd1;
				start = (write_point + amask) & ~amask;
				stop = start + bytes;
				if (stop <= BUFFER_BYTES) begin
					g.status = (start < fence && stop >= fence) ? ST_CROSSES : ST_IN_PLACE;
					g.offset = start[OFFSET_W-1:0];
					write_point = stop;
				end else if (bytes < fence) begin
					g.status = ST_WRAPPED;
					write_point = bytes;
				end
				status_count[g.status]++;
			end else begin
				frame_marks++;
				if (slot < FRAME_SLOTS) begin
					frame_starts[slot] = write_point;
					prev = (slot + FRAME_SLOTS - 1) % FRAME_SLOTS;
					fence = frame_starts[prev];
					g.status = ST_IN_PLACE;
				end
				g.offset = fence[OFFSET_W-1:0];
			end
			awaited_grants.push_back(g);
		endfunction

		task report(string field, longint unsigned want, longint unsigned got);
			$display("testbench: mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		endtask

		task check_result(logic [TDATA_OUT_W-1:0] data, logic [STATUS_W-1:0] user);
			grant_t g;
			if (awaited_grants.size() == 0) begin
				report("unexpected beat offset", 0, data);
			end else begin
				g = awaited_grants.pop_front();
				if (data[OFFSET_W-1:0] !== g.offset)
					report("offset", g.offset, data[OFFSET_W-1:0]);
				if (data[TDATA_OUT_W-1:OFFSET_W] !== '0)
					report("padding", 0, data[TDATA_OUT_W-1:OFFSET_W]);
				if (user !== g.status)
					report("status", g.status, user);
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;

	grant_scoreboard ledger;
	bit              calm;
	int              cycle_count;

	frame_fenced_ring_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : result_sink
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= calm || ($urandom_range(99) >= 36);
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				ledger.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_beat(op_t op, logic [OFFSET_W-1:0] bytes,
			logic [ALIGN_W-1:0] align, logic [SLOT_W-1:0] slot);
		while (!calm && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {slot, align, bytes};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		ledger.note_request(op, bytes, align, slot);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (ledger.pending() != 0);
	endtask

	initial begin : stimulus
		op_t                 op;
		logic [OFFSET_W-1:0] bytes;
		logic [ALIGN_W-1:0]  align;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   last_slot;
		int unsigned         pick;

		ledger = new();
		calm = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(OP_ALLOC, 25'd0, 5'd0, 2'd0);
		send_beat(OP_ALLOC, 25'd100, 5'd0, 2'd3);
		send_beat(OP_ALLOC, 25'd1, 5'd4, 2'd0);
		send_beat(OP_ALLOC, 25'd1, 5'd16, 2'd0);
		send_beat(OP_FRAME, 25'h1FFFFFF, 5'd31, 2'd0);
		send_beat(OP_ALLOC, 25'h0400000, 5'd3, 2'd0);
		send_beat(OP_FRAME, 25'd0, 5'd0, 2'd1);
		send_beat(OP_ALLOC, 25'h1FFFFFF, 5'd0, 2'd0);
		send_beat(OP_ALLOC, 25'h1000000, 5'd0, 2'd0);
		send_beat(OP_ALLOC, 25'h0010000, 5'd31, 2'd0);
		send_beat(OP_ALLOC, 25'd1, 5'd0, 2'd0);
		send_beat(OP_ALLOC, 25'd5, 5'd0, 2'd0);
		send_beat(OP_FRAME, 25'd0, 5'd0, 2'd3);
		send_beat(OP_FRAME, 25'd0, 5'd0, 2'd2);
		send_beat(OP_ALLOC, 25'd64, 5'd17, 2'd0);
		send_beat(OP_ALLOC, 25'd64, 5'd30, 2'd0);
		send_beat(OP_ALLOC, 25'd0, 5'd31, 2'd0);
		send_beat(OP_ALLOC, 25'h1000000, 5'd0, 2'd0);
		send_beat(OP_ALLOC, 25'd0, 5'd0, 2'd0);
		send_beat(OP_FRAME, 25'd0, 5'd0, 2'd0);
		send_beat(OP_FRAME, 25'd0, 5'd0, 2'd1);
		send_beat(OP_FRAME, 25'd0, 5'd0, 2'd2);
		send_beat(OP_ALLOC, 25'h0FFFFFF, 5'd8, 2'd0);
		drain();

		last_slot = 2'd2;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			calm = (i >= 200 && i < 300);
			if (i % 125 == 60)
				drain();
			op = ($urandom_range(99) < 15) ? OP_FRAME : OP_ALLOC;
			pick = $urandom_range(99);
			if (pick < 5)
				bytes = '0;
			else if (pick < 45)
				bytes = OFFSET_W'($urandom_range(4096, 1));
			else if (pick < 75)
				bytes = OFFSET_W'($urandom_range(1 << 18, 1));
			else if (pick < 90)
				bytes = OFFSET_W'($urandom_range(1 << 21, 1));
			else if (pick < 95)
				bytes = OFFSET_W'($urandom_range(1 << 24, 1));
			else
				bytes = OFFSET_W'($urandom);
			align = ($urandom_range(99) < 80) ? ALIGN_W'($urandom_range(12))
				: ALIGN_W'($urandom_range(31));
			if ($urandom_range(99) < 85)
				slot = SLOT_W'((last_slot + 1) % FRAME_SLOTS);
			else
				slot = SLOT_W'($urandom_range(3));
			if (op == OP_FRAME && slot < FRAME_SLOTS)
				last_slot = slot;
			send_beat(op, bytes, align, slot);
		end
		calm = 1'b0;
		drain();
		repeat (8) @(negedge clk);

		$display("testbench: %0d allocs: %0d in place, %0d crossing, %0d wrapped, %0d refused",
			ledger.status_count[ST_IN_PLACE] + ledger.status_count[ST_CROSSES]
				+ ledger.status_count[ST_WRAPPED] + ledger.status_count[ST_REFUSED],
			ledger.status_count[ST_IN_PLACE], ledger.status_count[ST_CROSSES],
			ledger.status_count[ST_WRAPPED], ledger.status_count[ST_REFUSED]);
		$display("testbench: %0d frame marks, %0d mismatches", ledger.frame_marks,
			ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
